/* hdl/sacts_pkg.sv */
// Shared types, constants and codes for the set-associative cache tag store.
package sacts_pkg;

   localparam int SETS       = 64;
   localparam int SET_BITS   = $clog2(SETS);
   localparam int WAYS       = 8;
   localparam int WAY_BITS   = $clog2(WAYS);
   localparam int ADDR_BITS  = 31;
   localparam int STAMP_BITS = 32;
   localparam int LFSR_BITS  = 16;
   localparam logic [LFSR_BITS-1:0] LFSR_POLY = 16'hB400;
   localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'h0001;

   localparam int CSR_W   = 4;
   localparam int CSR_IDX = 2;
   localparam logic [CSR_IDX-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_IDX-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_IDX-1:0] CSR_INDEX  = 2'd2;
   localparam logic [CSR_IDX-1:0] CSR_WAYS   = 2'd3;

   localparam logic [1:0] POL_RANDOM  = 2'd0;
   localparam logic [1:0] POL_LRU     = 2'd1;
   localparam logic [1:0] POL_NOT_MRU = 2'd2;

   typedef struct packed {
      logic                 op;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic          hit;
      logic [2:0]    way;
      logic          dirty_eviction;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  tag;
      logic                  valid;
      logic                  dirty;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic sel;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_mod;
      logic out_free;
   } sts_type;

endpackage

/* hdl/sacts_ctrl.sv */
// Controller state machine sequencing lookup, victim choice and write-back.
module sacts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sacts_pkg::sts_type sts,
   output sacts_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVAL  = 3'd1;
   localparam logic [2:0] ST_SEL   = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam int CNT_W = $clog2(sacts_pkg::LFSR_BITS);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.sel = 1'b1;
            cnt_in  = '0;
            state_in = sts.need_mod ? ST_MOD : ST_WRITE;
         end
         ST_MOD: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(sacts_pkg::LFSR_BITS - 1)) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* hdl/sacts_dp.sv */
// Datapath: set memory, tag compare, victim trees, remainder unit and output register.
module sacts_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sacts_pkg::req_type                   req_payload,
   input  logic                                 csr_wr_en,
   input  logic [sacts_pkg::CSR_IDX-1:0]        csr_index,
   input  logic [sacts_pkg::CSR_W-1:0]          csr_wdata,
   input  sacts_pkg::cmd_type                   cmd,
   output sacts_pkg::sts_type                   sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sacts_pkg::rsp_type                   rsp_payload
);

   localparam int W   = sacts_pkg::WAYS;
   localparam int WB  = sacts_pkg::WAY_BITS;
   localparam int SB  = sacts_pkg::SET_BITS;
   localparam int AB  = sacts_pkg::ADDR_BITS;
   localparam int STB = sacts_pkg::STAMP_BITS;
   localparam int LB  = sacts_pkg::LFSR_BITS;
   localparam int NW  = WB + 1;

   typedef struct packed {
      logic           en;
      logic [STB-1:0] st;
      logic [WB-1:0]  idx;
   } node_type;

   // configuration
   logic [1:0] policy_ff;
   logic [3:0] offset_ff;
   logic [2:0] ibits_ff;
   logic [3:0] ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= sacts_pkg::POL_LRU;
         offset_ff <= 4'd4;
         ibits_ff  <= 3'd6;
         ways_ff   <= 4'd8;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sacts_pkg::CSR_POLICY: policy_ff <= csr_wdata[1:0];
            sacts_pkg::CSR_OFFSET: offset_ff <= csr_wdata[3:0];
            sacts_pkg::CSR_INDEX:  ibits_ff  <= csr_wdata[2:0];
            sacts_pkg::CSR_WAYS:   ways_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // address split
   logic [2:0]    ib;
   logic [NW-1:0] nways_in;
   logic [AB-1:0] addr_off;
   logic [SB-1:0] set_in;
   logic [AB-1:0] tag_in;

   always_comb begin
      ib = (ibits_ff > 3'(SB)) ? 3'(SB) : ibits_ff;
      if (ways_ff == '0)          nways_in = NW'(1);
      else if (ways_ff > 4'(W))   nways_in = NW'(W);
      else                        nways_in = NW'(ways_ff);
      addr_off = req_payload.address >> offset_ff;
      set_in   = addr_off[SB-1:0] & ~({SB{1'b1}} << ib);
      tag_in   = req_payload.address >> (5'(offset_ff) + 5'(ib));
   end

   // request registers and set memory
   sacts_pkg::row_type mem_q [sacts_pkg::SETS];
   sacts_pkg::row_type rd_row_ff, row, new_row;
   logic [sacts_pkg::SETS-1:0] touched_ff;
   logic          row_ok_ff;
   logic          op_ff;
   logic [SB-1:0] set_ff;
   logic [AB-1:0] tag_ff;
   logic [NW-1:0] nways_ff;
   logic [1:0]    pol_ff;
   logic [STB-1:0] clk_ff, stamp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_row_ff <= mem_q[set_in];
         op_ff     <= req_payload.op;
         set_ff    <= set_in;
         tag_ff    <= tag_in;
         nways_ff  <= nways_in;
         pol_ff    <= policy_ff;
      end
      if (cmd.commit) mem_q[set_ff] <= new_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= '0;
         row_ok_ff  <= 1'b0;
         clk_ff     <= '0;
      end else begin
         if (cmd.load) begin
            row_ok_ff <= touched_ff[set_in];
            if (clk_ff != {STB{1'b1}}) clk_ff <= clk_ff + 1'b1;
         end
         if (cmd.commit) touched_ff[set_ff] <= 1'b1;
      end
   end

   assign stamp_ff = clk_ff;
   assign row      = row_ok_ff ? rd_row_ff : '0;

   // evaluation
   logic [W-1:0]  in_use, hitv, invv;
   logic          hit_c, inv_c;
   logic [WB-1:0] hway_c, iway_c;
   node_type      l1 [4];
   node_type      l2 [2];
   node_type      lru_c;
   logic [STB-1:0] m1 [4];
   logic [STB-1:0] m2 [2];
   logic [STB-1:0] newest_c;

   function automatic node_type pick_old(node_type a, node_type b);
      if (!b.en)              return a;
      else if (!a.en)         return b;
      else if (b.st <= a.st)  return b;
      else                    return a;
   endfunction

   always_comb begin
      hit_c  = 1'b0;
      inv_c  = 1'b0;
      hway_c = '0;
      iway_c = '0;
      for (int w = 0; w < W; w++) begin
         in_use[w] = (NW'(w) < nways_ff);
         hitv[w]   = in_use[w] && row[w].valid && (row[w].tag == tag_ff);
         invv[w]   = in_use[w] && !row[w].valid;
      end
      for (int w = W - 1; w >= 0; w--) begin
         if (hitv[w]) begin
            hit_c  = 1'b1;
            hway_c = WB'(w);
         end
         if (invv[w]) begin
            inv_c  = 1'b1;
            iway_c = WB'(w);
         end
      end
      for (int i = 0; i < 4; i++) begin
         l1[i] = pick_old('{in_use[2*i], row[2*i].stamp, WB'(2*i)},
                          '{in_use[2*i+1], row[2*i+1].stamp, WB'(2*i+1)});
         m1[i] = ((in_use[2*i] ? row[2*i].stamp : '0) > (in_use[2*i+1] ? row[2*i+1].stamp : '0))
                 ? (in_use[2*i] ? row[2*i].stamp : '0)
                 : (in_use[2*i+1] ? row[2*i+1].stamp : '0);
      end
      for (int i = 0; i < 2; i++) begin
         l2[i] = pick_old(l1[2*i], l1[2*i+1]);
         m2[i] = (m1[2*i] > m1[2*i+1]) ? m1[2*i] : m1[2*i+1];
      end
      lru_c    = pick_old(l2[0], l2[1]);
      newest_c = (m2[0] > m2[1]) ? m2[0] : m2[1];
   end

   logic           hit_ff, inv_ff;
   logic [WB-1:0]  hway_ff, iway_ff, lru_ff, pick_ff;
   logic [STB-1:0] newest_ff;
   logic           rnd_ff;
   logic [WB-1:0]  nmru_c;
   logic [LB-1:0]  lfsr_ff, lfsr_nx;
   logic [LB-1:0]  div_ff;
   logic [WB-1:0]  rem_ff;
   logic [WB:0]    r2;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         hit_ff    <= hit_c;
         inv_ff    <= inv_c;
         hway_ff   <= hway_c;
         iway_ff   <= iway_c;
         lru_ff    <= lru_c.idx;
         newest_ff <= newest_c;
      end
   end

   assign sts.need_mod = !hit_ff && !inv_ff && (pol_ff == sacts_pkg::POL_RANDOM);

   always_comb begin
      nmru_c = '0;
      for (int w = W - 1; w >= 0; w--)
         if (in_use[w] && (row[w].stamp < newest_ff)) nmru_c = WB'(w);
      lfsr_nx = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? sacts_pkg::LFSR_POLY : '0);
      r2 = {rem_ff, div_ff[LB-1]};
      if (r2 >= (WB+1)'(nways_ff)) r2 = r2 - (WB+1)'(nways_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) lfsr_ff <= sacts_pkg::LFSR_SEED;
      else if (cmd.sel && sts.need_mod) lfsr_ff <= lfsr_nx;
   end

   always_ff @(posedge clock) begin
      if (cmd.sel) begin
         rnd_ff <= sts.need_mod;
         div_ff <= lfsr_nx;
         rem_ff <= '0;
         if (hit_ff)                               pick_ff <= hway_ff;
         else if (inv_ff)                          pick_ff <= iway_ff;
         else if (pol_ff == sacts_pkg::POL_NOT_MRU) pick_ff <= nmru_c;
         else                                      pick_ff <= lru_ff;
      end else if (cmd.step) begin
         rem_ff <= r2[WB-1:0];
         div_ff <= div_ff << 1;
      end
   end

   // write-back row and result
   logic [WB-1:0] pick;
   logic          dev;

   always_comb begin
      pick    = rnd_ff ? rem_ff : pick_ff;
      dev     = !hit_ff && !inv_ff && row[pick].dirty;
      new_row = row;
      new_row[pick].stamp = stamp_ff;
      if (hit_ff) begin
         new_row[pick].dirty = row[pick].dirty | op_ff;
      end else begin
         new_row[pick].valid = 1'b1;
         new_row[pick].tag   = tag_ff;
         new_row[pick].dirty = op_ff;
      end
   end

   logic rsp_valid_ff;
   sacts_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.hit            <= hit_ff;
         rsp_ff.way            <= 3'(pick);
         rsp_ff.dirty_eviction <= dev;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

endmodule

/* hdl/set_assoc_cache_tag_store_core.sv */
// Top level of the set-associative write-back cache tag store.
// Requests (op, address) arrive on req_valid/req_ready; one response
// (hit, way, dirty_eviction) per transaction leaves on rsp_valid/rsp_ready.
// One transaction is processed at a time: req_ready is high only while idle.
// A transaction goes from acceptance to rsp_valid through compare and victim
// trees, selection, and write-back with response load; a miss with every way
// valid under the random policy adds a bit-serial remainder of the LFSR value
// by the way count. The set memory has one read and one write per
// transaction; a new request is accepted only after the last is written back.
// The response register lets the next request be accepted while a result
// waits; if rsp_ready stays low the write-back stage holds until the
// register frees.
// Reset sets configuration to defaults, clears the stamp counter and the
// per-set touched flags and loads the LFSR seed, so all ways read as
// invalid and clean at once; no clearing pass is needed.
// Configuration is written through csr_wr_en/csr_index/csr_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
module set_assoc_cache_tag_store_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sacts_pkg::req_type            req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sacts_pkg::rsp_type            rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [sacts_pkg::CSR_IDX-1:0] csr_index,
   input  logic [sacts_pkg::CSR_W-1:0]   csr_wdata
);

   sacts_pkg::cmd_type cmd;
   sacts_pkg::sts_type sts;

   sacts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sacts_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.eval, cmd.sel, cmd.step, cmd.commit}))
      else $error("more than one datapath command");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.hit && rsp_payload.dirty_eviction))
      else $error("hit reported with dirty eviction");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("response overwritten");

endmodule
